@@ rtl/bat_pkg.sv @@
// Shared types and constants for the bounds affine transform core.
`default_nettype none
package bat_pkg;

  localparam int COORD_W = 32;
  localparam int HALF_W  = COORD_W - 1;
  localparam int ENTRY_W = 20;
  localparam int ROW_W   = 3 * ENTRY_W;
  localparam int CFG_W   = ROW_W;
  localparam int IDX_W   = 3;
  localparam int SCALE_W = 20;

  localparam logic [IDX_W-1:0] REG_BASIS_0 = 3'd0;
  localparam logic [IDX_W-1:0] REG_BASIS_1 = 3'd1;
  localparam logic [IDX_W-1:0] REG_BASIS_2 = 3'd2;
  localparam logic [IDX_W-1:0] REG_OFFSET_X = 3'd3;
  localparam logic [IDX_W-1:0] REG_OFFSET_Y = 3'd4;
  localparam logic [IDX_W-1:0] REG_OFFSET_Z = 3'd5;

  localparam logic [SCALE_W-1:0] UNIT_SCALE = 20'd65536;

  typedef logic [2:0][ROW_W-1:0] basis_t;
  typedef logic signed [2:0][COORD_W-1:0] offset_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic [HALF_W-1:0] half_size_x;
    logic [HALF_W-1:0] half_size_y;
    logic [HALF_W-1:0] half_size_z;
    logic [HALF_W-1:0] radius;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_center_x;
    logic signed [COORD_W-1:0] out_center_y;
    logic signed [COORD_W-1:0] out_center_z;
    logic [HALF_W-1:0] out_half_size_x;
    logic [HALF_W-1:0] out_half_size_y;
    logic [HALF_W-1:0] out_half_size_z;
    logic [HALF_W-1:0] out_radius;
  } out_item_t;

endpackage
`default_nettype wire

@@ rtl/bat_scale_unit.sv @@
// Sequential radius scale unit: column sums of squares, max, bitwise square root.
`default_nettype none
module bat_scale_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire bat_pkg::basis_t               basis,
  output logic                               busy,
  output logic [bat_pkg::SCALE_W-1:0]        scale
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SQ   = 2'd1;
  localparam logic [1:0] ST_ROOT = 2'd2;

  localparam int SQ_W  = 2 * bat_pkg::ENTRY_W;
  localparam int SUM_W = SQ_W;
  localparam int RT_W  = SUM_W + 1;

  logic [1:0] state_r, state_nxt;
  logic [1:0] row_r, row_nxt;
  logic [1:0] col_r, col_nxt;
  logic [SUM_W-1:0] colsum_r, colsum_nxt;
  logic [SUM_W-1:0] best_r, best_nxt;
  logic [RT_W-1:0] v_r, v_nxt;
  logic [RT_W-1:0] root_r, root_nxt;
  logic [RT_W-1:0] bit_r, bit_nxt;
  logic [bat_pkg::SCALE_W-1:0] scale_r, scale_nxt;

  logic signed [bat_pkg::ENTRY_W-1:0] e;
  logic signed [SQ_W-1:0] sq;
  logic [SUM_W-1:0] sum;
  logic [RT_W-1:0] trial;

  always_comb begin
    e = $signed(basis[row_r][col_r*bat_pkg::ENTRY_W +: bat_pkg::ENTRY_W]);
    sq = e * e;
    sum = ((row_r == 2'd0) ? '0 : colsum_r) + SUM_W'($unsigned(sq));
    trial = root_r + bit_r;
    state_nxt = state_r;
    row_nxt = row_r;
    col_nxt = col_r;
    colsum_nxt = colsum_r;
    best_nxt = best_r;
    v_nxt = v_r;
    root_nxt = root_r;
    bit_nxt = bit_r;
    scale_nxt = scale_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_SQ;
          row_nxt = 2'd0;
          col_nxt = 2'd0;
          best_nxt = '0;
        end
      end
      ST_SQ: begin
        colsum_nxt = sum;
        if (row_r == 2'd2) begin
          row_nxt = 2'd0;
          if (sum > best_r) begin
            best_nxt = sum;
          end
          if (col_r == 2'd2) begin
            state_nxt = ST_ROOT;
            v_nxt = RT_W'(best_nxt);
            root_nxt = '0;
            bit_nxt = RT_W'(1) << (SUM_W - 2);
          end else begin
            col_nxt = col_r + 2'd1;
          end
        end else begin
          row_nxt = row_r + 2'd1;
        end
      end
      ST_ROOT: begin
        if (v_r >= trial) begin
          v_nxt = v_r - trial;
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r == RT_W'(1)) begin
          state_nxt = ST_IDLE;
          scale_nxt = root_nxt[bat_pkg::SCALE_W-1:0];
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      scale_r <= bat_pkg::UNIT_SCALE;
    end else begin
      state_r <= state_nxt;
      scale_r <= scale_nxt;
    end
    row_r <= row_nxt;
    col_r <= col_nxt;
    colsum_r <= colsum_nxt;
    best_r <= best_nxt;
    v_r <= v_nxt;
    root_r <= root_nxt;
    bit_r <= bit_nxt;
  end

  assign busy = (state_r != ST_IDLE);
  assign scale = scale_r;

endmodule
`default_nettype wire

@@ rtl/bat_datapath.sv @@
// Four-stage transform pipeline: capture, multiply, sum, round and saturate.
`default_nettype none
module bat_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire bat_pkg::in_item_t             in_item,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output bat_pkg::out_item_t                 out_item,
  input  wire bat_pkg::basis_t               basis,
  input  wire bat_pkg::offset_t              offset,
  input  wire logic [bat_pkg::SCALE_W-1:0]   scale
);

  localparam int CW   = bat_pkg::COORD_W;
  localparam int HW   = bat_pkg::HALF_W;
  localparam int EW   = bat_pkg::ENTRY_W;
  localparam int CP_W = CW + EW;
  localparam int EP_W = HW + EW;
  localparam int RP_W = HW + bat_pkg::SCALE_W;
  localparam int AC_W = CP_W + 3;
  localparam int EX_W = EP_W + 2;
  localparam int RC_W = AC_W - 16;
  localparam int RE_W = EX_W - 16;
  localparam int RR_W = RP_W - 16;
  localparam logic signed [RC_W-1:0] SMAX = RC_W'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [RC_W-1:0] SMIN = -SMAX - RC_W'(1);
  localparam logic [RE_W-1:0] EMAX = RE_W'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic [RR_W-1:0] RMAX = RR_W'((64'd1 << (CW - 1)) - 64'd1);

  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic rdy1, rdy2, rdy3, rdy4;
  bat_pkg::in_item_t s1_item_r;
  logic signed [2:0][2:0][CP_W-1:0] s2_cp_r, s2_cp_nxt;
  logic [2:0][2:0][EP_W-1:0] s2_ep_r, s2_ep_nxt;
  logic [RP_W-1:0] s2_rp_r, s2_rp_nxt;
  logic signed [2:0][AC_W-1:0] s3_acc_r, s3_acc_nxt;
  logic [2:0][EX_W-1:0] s3_ext_r, s3_ext_nxt;
  logic [RP_W-1:0] s3_rp_r;
  logic signed [2:0][CW-1:0] s4_c_r, s4_c_nxt;
  logic [2:0][HW-1:0] s4_h_r, s4_h_nxt;
  logic [HW-1:0] s4_r_r, s4_r_nxt;

  logic signed [CW-1:0] cin [3];
  logic [HW-1:0] hin [3];
  logic signed [EW-1:0] ent [3][3];
  logic [EW-1:0] aent [3][3];
  logic signed [AC_W-1:0] acc_t, acc_s;
  logic [EX_W-1:0] ext_t;
  logic [RE_W-1:0] ext_s;
  logic [RP_W-1:0] rad_t;
  logic [RR_W-1:0] rad_s;

  assign rdy4 = !s4_v_r || !out_stall;
  assign rdy3 = !s3_v_r || rdy4;
  assign rdy2 = !s2_v_r || rdy3;
  assign rdy1 = !s1_v_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    cin[0] = s1_item_r.center_x;
    cin[1] = s1_item_r.center_y;
    cin[2] = s1_item_r.center_z;
    hin[0] = s1_item_r.half_size_x;
    hin[1] = s1_item_r.half_size_y;
    hin[2] = s1_item_r.half_size_z;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        ent[i][j] = $signed(basis[i][j*EW +: EW]);
        aent[i][j] = ent[i][j][EW-1] ? EW'(-ent[i][j]) : EW'(ent[i][j]);
        s2_cp_nxt[i][j] = CP_W'(cin[i]) * CP_W'(ent[i][j]);
        s2_ep_nxt[i][j] = EP_W'(hin[i]) * EP_W'(aent[i][j]);
      end
    end
    s2_rp_nxt = RP_W'(s1_item_r.radius) * RP_W'(scale);
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      s3_acc_nxt[j] = AC_W'($signed(s2_cp_r[0][j])) + AC_W'($signed(s2_cp_r[1][j]))
                    + AC_W'($signed(s2_cp_r[2][j]))
                    + AC_W'($signed({offset[j], 16'd0}));
      s3_ext_nxt[j] = EX_W'(s2_ep_r[0][j]) + EX_W'(s2_ep_r[1][j]) + EX_W'(s2_ep_r[2][j]);
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      acc_t = s3_acc_r[j] + AC_W'(32768);
      acc_s = acc_t >>> 16;
      if ($signed(acc_s[RC_W-1:0]) > SMAX) begin
        s4_c_nxt[j] = CW'(SMAX);
      end else if ($signed(acc_s[RC_W-1:0]) < SMIN) begin
        s4_c_nxt[j] = CW'(SMIN);
      end else begin
        s4_c_nxt[j] = acc_s[CW-1:0];
      end
      ext_t = s3_ext_r[j] + EX_W'(32768);
      ext_s = ext_t[EX_W-1:16];
      s4_h_nxt[j] = (ext_s > EMAX) ? HW'(EMAX) : ext_s[HW-1:0];
    end
    rad_t = s3_rp_r + RP_W'(32768);
    rad_s = rad_t[RP_W-1:16];
    s4_r_nxt = (rad_s > RMAX) ? HW'(RMAX) : rad_s[HW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (rdy1) s1_v_r <= in_valid;
      if (rdy2) s2_v_r <= s1_v_r;
      if (rdy3) s3_v_r <= s2_v_r;
      if (rdy4) s4_v_r <= s3_v_r;
    end
    if (rdy1) s1_item_r <= in_item;
    if (rdy2) begin
      s2_cp_r <= s2_cp_nxt;
      s2_ep_r <= s2_ep_nxt;
      s2_rp_r <= s2_rp_nxt;
    end
    if (rdy3) begin
      s3_acc_r <= s3_acc_nxt;
      s3_ext_r <= s3_ext_nxt;
      s3_rp_r <= s2_rp_r;
    end
    if (rdy4) begin
      s4_c_r <= s4_c_nxt;
      s4_h_r <= s4_h_nxt;
      s4_r_r <= s4_r_nxt;
    end
  end

  assign out_valid = s4_v_r;
  assign out_item.out_center_x = s4_c_r[0];
  assign out_item.out_center_y = s4_c_r[1];
  assign out_item.out_center_z = s4_c_r[2];
  assign out_item.out_half_size_x = s4_h_r[0];
  assign out_item.out_half_size_y = s4_h_r[1];
  assign out_item.out_half_size_z = s4_h_r[2];
  assign out_item.out_radius = s4_r_r;

endmodule
`default_nettype wire

@@ rtl/bounds_affine_transform_core.sv @@
// Top level: configuration registers, radius scale unit and transform pipeline.
// The result passes through four register stages: capture, multiply, sum, round and saturate.
// Throughput: one item per cycle while the output is not stalled and the scale unit is not busy.
// A basis row write starts the radius scale unit: 9 square steps plus 20 root steps,
// during which input and configuration are stalled.
// Synchronous active-low reset loads the identity basis, zero offsets and unit scale.
`default_nettype none
module bounds_affine_transform_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire bat_pkg::in_item_t             in_item,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output bat_pkg::out_item_t                 out_item,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [bat_pkg::IDX_W-1:0]     cfg_index,
  input  wire logic [bat_pkg::CFG_W-1:0]     cfg_data
);

  localparam int EW = bat_pkg::ENTRY_W;
  localparam int CW = bat_pkg::COORD_W;

  bat_pkg::basis_t basis_r;
  bat_pkg::offset_t offset_r;
  logic busy, dp_ready, cfg_wr, start;
  logic [bat_pkg::SCALE_W-1:0] scale;

  assign cfg_ready = !busy;
  assign cfg_wr = cfg_valid && cfg_ready;
  assign start = cfg_wr && (cfg_index == bat_pkg::REG_BASIS_0 ||
                            cfg_index == bat_pkg::REG_BASIS_1 ||
                            cfg_index == bat_pkg::REG_BASIS_2);
  assign in_stall = busy || !dp_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      basis_r[0] <= bat_pkg::ROW_W'(65536);
      basis_r[1] <= bat_pkg::ROW_W'(65536) << EW;
      basis_r[2] <= bat_pkg::ROW_W'(65536) << (2 * EW);
      offset_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        bat_pkg::REG_BASIS_0:  basis_r[0] <= cfg_data[bat_pkg::ROW_W-1:0];
        bat_pkg::REG_BASIS_1:  basis_r[1] <= cfg_data[bat_pkg::ROW_W-1:0];
        bat_pkg::REG_BASIS_2:  basis_r[2] <= cfg_data[bat_pkg::ROW_W-1:0];
        bat_pkg::REG_OFFSET_X: offset_r[0] <= cfg_data[CW-1:0];
        bat_pkg::REG_OFFSET_Y: offset_r[1] <= cfg_data[CW-1:0];
        bat_pkg::REG_OFFSET_Z: offset_r[2] <= cfg_data[CW-1:0];
        default: begin
        end
      endcase
    end
  end

  bat_scale_unit u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .basis (basis_r),
    .busy  (busy),
    .scale (scale)
  );

  bat_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid && !busy),
    .in_ready  (dp_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .basis     (basis_r),
    .offset    (offset_r),
    .scale     (scale)
  );

`ifndef SYNTHESIS
  a_busy_stalls_in: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> in_stall) else $error("input taken while scale unit busy");
  a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy) else $error("basis write did not start scale unit");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !start) else $error("basis write while scale unit busy");
`endif

endmodule
`default_nettype wire
